// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the triangle adjacency core RTL.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLKRST(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed: %m");
`define ASSERT_CLK(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("assertion failed: %m");
`else
`define ASSERT_CLKRST(lbl, clk, rst_n, prop)
`define ASSERT_CLK(lbl, clk, prop)
`endif
`endif

// ===== hw/rtl/tab_pkg.sv =====
// Types and fixed constants of the triangle adjacency builder.
// No dependencies.
`default_nettype none
package tab_pkg;

	localparam int QUERY_W    = 10;
	localparam int VERT_OUT_W = 16;

	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_QUERY = 2'd1,
		MODE_CLEAR = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_HEAD  = 4'b0010,
		ST_SCAN  = 4'b0100,
		ST_DRAIN = 4'b1000
	} state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/triangle_adjacency_builder_core.sv =====
// Top level of the triangle adjacency builder: command decode, table and scan control.
// Depends on tab_pkg, tab_ram, tab_cell and assert_macros.svh.
//
//   channel  | handshake           | words
//   ---------+---------------------+------------------------------------------------
//   command  | start high, busy low| mode, vertex_a/b/c, query_triangle
//   result   | strobe, one cycle   | valid_res, corner_a/b/c, across_ab/bc/ca
//
// Load and clear leave busy low and produce no result.
// A query beyond the stored count answers with strobe in the cycle after acceptance.
// During a valid query the table is read one stored triangle per cycle from its
// single read port, and each one walks a chain of three cells.
// Reset clears the count, the control state and the strobe; the table holds no reset.
// Results cannot be stalled; strobe lasts exactly one cycle per query.
`default_nettype none
`include "assert_macros.svh"
module triangle_adjacency_builder_core #(
	parameter int MAX_TRIANGLES = 1024,
	parameter int INDEX_BITS    = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    mode,
	input  logic [INDEX_BITS-1:0]         vertex_a,
	input  logic [INDEX_BITS-1:0]         vertex_b,
	input  logic [INDEX_BITS-1:0]         vertex_c,
	input  logic [tab_pkg::QUERY_W-1:0]   query_triangle,
	output logic                          strobe,
	output logic                          valid_res,
	output logic [tab_pkg::VERT_OUT_W-1:0] corner_a,
	output logic [tab_pkg::VERT_OUT_W-1:0] across_ab,
	output logic [tab_pkg::VERT_OUT_W-1:0] corner_b,
	output logic [tab_pkg::VERT_OUT_W-1:0] across_bc,
	output logic [tab_pkg::VERT_OUT_W-1:0] corner_c,
	output logic [tab_pkg::VERT_OUT_W-1:0] across_ca
);

	localparam int W    = INDEX_BITS;
	localparam int TW   = 3 * INDEX_BITS;
	localparam int AW   = $clog2(MAX_TRIANGLES);
	localparam int CW   = $clog2(MAX_TRIANGLES + 1);
	localparam int QW   = tab_pkg::QUERY_W;
	localparam int CMPW = (CW > QW) ? CW : QW;
	localparam int OW   = tab_pkg::VERT_OUT_W;
	localparam int NCELL = 3;

	tab_pkg::state_t state_q;
	logic [CW-1:0]   count_q;
	logic [AW-1:0]   idx_q;
	logic            feed_s1;
	logic            strobe_q;
	logic            accept, q_hit, full, last, chain_busy, load_cells, wr_en;
	logic [AW-1:0]   rd_addr;
	logic [TW-1:0]   rd_data;

	logic [TW-1:0]   link_d [NCELL+1];
	logic [NCELL:0]  link_v;
	logic [W-1:0]    cell_corner [NCELL];
	logic [W-1:0]    cell_across [NCELL];

	logic            valid_q;
	logic [OW-1:0]   ca_q, cb_q, cc_q, xab_q, xbc_q, xca_q;

	assign busy       = (state_q != tab_pkg::ST_IDLE);
	assign accept     = start && !busy;
	assign q_hit      = CMPW'(query_triangle) < CMPW'(count_q);
	assign full       = (count_q == CW'(MAX_TRIANGLES));
	assign last       = ((CW'(idx_q) + CW'(1)) == count_q);
	assign chain_busy = |link_v;
	assign load_cells = (state_q == tab_pkg::ST_HEAD);
	assign wr_en      = accept && (mode == tab_pkg::MODE_LOAD) && !full;
	assign rd_addr    = (state_q == tab_pkg::ST_IDLE) ? AW'(query_triangle) : idx_q;

	tab_ram #(
		.WIDTH(TW),
		.DEPTH(MAX_TRIANGLES)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(count_q[AW-1:0]),
		.wr_data({vertex_c, vertex_b, vertex_a}),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign link_d[0] = rd_data;
	assign link_v[0] = feed_s1;

	// cell g searches edge g: corner g to the next corner, own vertex is the third
	for (genvar g = 0; g < NCELL; g++) begin : g_cell
		tab_cell #(
			.W(W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.load      (load_cells),
			.p_in      (rd_data[(g % 3) * W +: W]),
			.q_in      (rd_data[((g + 1) % 3) * W +: W]),
			.own_in    (rd_data[((g + 2) % 3) * W +: W]),
			.cand_in   (link_d[g]),
			.cand_v_in (link_v[g]),
			.cand_out  (link_d[g+1]),
			.cand_v_out(link_v[g+1]),
			.corner    (cell_corner[g]),
			.across    (cell_across[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= tab_pkg::ST_IDLE;
			count_q  <= '0;
			idx_q    <= '0;
			feed_s1  <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			feed_s1  <= 1'b0;
			case (state_q)
				tab_pkg::ST_IDLE: begin
					if (accept) begin
						case (tab_pkg::mode_t'(mode))
							tab_pkg::MODE_LOAD: begin
								if (!full) begin
									count_q <= count_q + CW'(1);
								end
							end
							tab_pkg::MODE_QUERY: begin
								if (q_hit) begin
									idx_q   <= '0;
									state_q <= tab_pkg::ST_HEAD;
								end else begin
									strobe_q <= 1'b1;
								end
							end
							tab_pkg::MODE_CLEAR: begin
								count_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				tab_pkg::ST_HEAD, tab_pkg::ST_SCAN: begin
					// issue one table read per cycle into the head of the chain
					feed_s1 <= 1'b1;
					idx_q   <= idx_q + AW'(1);
					state_q <= last ? tab_pkg::ST_DRAIN : tab_pkg::ST_SCAN;
				end
				tab_pkg::ST_DRAIN: begin
					if (!chain_busy) begin
						strobe_q <= 1'b1;
						state_q  <= tab_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= tab_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (mode == tab_pkg::MODE_QUERY) && !q_hit) begin
			valid_q <= 1'b0;
			ca_q    <= '0;
			cb_q    <= '0;
			cc_q    <= '0;
			xab_q   <= '0;
			xbc_q   <= '0;
			xca_q   <= '0;
		end else if ((state_q == tab_pkg::ST_DRAIN) && !chain_busy) begin
			valid_q <= 1'b1;
			ca_q    <= OW'(cell_corner[0]);
			cb_q    <= OW'(cell_corner[1]);
			cc_q    <= OW'(cell_corner[2]);
			xab_q   <= OW'(cell_across[0]);
			xbc_q   <= OW'(cell_across[1]);
			xca_q   <= OW'(cell_across[2]);
		end
	end

	assign strobe    = strobe_q;
	assign valid_res = valid_q;
	assign corner_a  = ca_q;
	assign corner_b  = cb_q;
	assign corner_c  = cc_q;
	assign across_ab = xab_q;
	assign across_bc = xbc_q;
	assign across_ca = xca_q;

	`ASSERT_CLK(a_count_range, clk, !arst_n || (count_q <= CW'(MAX_TRIANGLES)))
	`ASSERT_CLKRST(a_count_held_busy, clk, arst_n, busy |=> (count_q == $past(count_q)))
	`ASSERT_CLKRST(a_chain_empty_idle, clk, arst_n, !busy |-> (link_v == '0))
	`ASSERT_CLKRST(a_miss_zero, clk, arst_n, (strobe && !valid_res) |-> ((across_ab == '0) && (across_bc == '0) && (across_ca == '0)))

endmodule
`default_nettype wire

// ===== hw/rtl/tab_ram.sv =====
// Generic single-port-write, registered-read RAM.
// No dependencies.
`default_nettype none
module tab_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

// ===== hw/rtl/tab_cell.sv =====
// One search cell: holds one edge of the queried triangle and the first
// neighbour found across it; passes each candidate triangle on. No dependencies.
`default_nettype none
module tab_cell #(
	parameter int W = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  logic [W-1:0] p_in,
	input  logic [W-1:0] q_in,
	input  logic [W-1:0] own_in,
	input  logic [3*W-1:0] cand_in,
	input  logic         cand_v_in,
	output logic [3*W-1:0] cand_out,
	output logic         cand_v_out,
	output logic [W-1:0] corner,
	output logic [W-1:0] across
);

	logic [W-1:0]   p_q, q_q, own_q, across_q;
	logic [3*W-1:0] cand_q;
	logic           cand_v_q, found_q;
	logic [W-1:0]   t0, t1, t2, take_val;
	logic           m0, m1, m2, take;

	always_comb begin
		t0 = cand_in[0 +: W];
		t1 = cand_in[W +: W];
		t2 = cand_in[2*W +: W];
		m0 = ((t0 == p_q && t1 == q_q) || (t0 == q_q && t1 == p_q)) && (t2 != own_q);
		m1 = ((t1 == p_q && t2 == q_q) || (t1 == q_q && t2 == p_q)) && (t0 != own_q);
		m2 = ((t2 == p_q && t0 == q_q) || (t2 == q_q && t0 == p_q)) && (t1 != own_q);
		take = cand_v_in && !found_q && (m0 || m1 || m2);
		// earlier edge of the candidate wins
		if (m0) begin
			take_val = t2;
		end else if (m1) begin
			take_val = t0;
		end else begin
			take_val = t1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_v_q <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			cand_v_q <= cand_v_in;
			if (load) begin
				found_q <= 1'b0;
			end else if (take) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		cand_q <= cand_in;
		if (load) begin
			p_q      <= p_in;
			q_q      <= q_in;
			own_q    <= own_in;
			across_q <= '0;
		end else if (take) begin
			across_q <= take_val;
		end
	end

	assign cand_out   = cand_q;
	assign cand_v_out = cand_v_q;
	assign corner     = p_q;
	assign across     = across_q;

endmodule
`default_nettype wire

// ===== test/triangle_adjacency_builder_core_test.sv =====
// Self-checking testbench for triangle_adjacency_builder_core: loads, clears and adjacency queries.
// Depends on tab_pkg and the core RTL; it carries its own table model for the expected records.
module triangle_adjacency_builder_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_TRI = 1024;
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int STALL_LIMIT = 8000;
	localparam int RANDOM_ITEMS = 560;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] va, vb, vc;
		logic [9:0]  qt;
	} cmd_word_t;

	typedef struct packed {
		logic        valid;
		logic [15:0] ca, ab, cb, bc, cc, ac;
	} adj_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] mode = tab_pkg::MODE_LOAD;
	logic [15:0] vertex_a = '0;
	logic [15:0] vertex_b = '0;
	logic [15:0] vertex_c = '0;
	logic [tab_pkg::QUERY_W-1:0] query_triangle = '0;
	logic busy, strobe, valid_res;
	logic [tab_pkg::VERT_OUT_W-1:0] corner_a, across_ab, corner_b, across_bc, corner_c, across_ca;

	triangle_adjacency_builder_core u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.vertex_a(vertex_a), .vertex_b(vertex_b), .vertex_c(vertex_c),
		.query_triangle(query_triangle), .strobe(strobe), .valid_res(valid_res),
		.corner_a(corner_a), .across_ab(across_ab), .corner_b(corner_b),
		.across_bc(across_bc), .corner_c(corner_c), .across_ca(across_ca)
	);

	always #2 clk = ~clk;

	cmd_word_t cmd_backlog[$];
	adj_word_t adj_expected[$];

	// table model seen by the checker
	logic [15:0] mesh_vtx [0:NUM_TRI-1][0:2];
	int unsigned mesh_len = 0;

	// shadow of the table kept while the stimulus is built, for shared edges
	logic [15:0] gen_v [0:NUM_TRI-1][0:2];
	int gen_len = 0;

	int errors = 0;
	int stall_cycles = 0;
	int n_checked = 0, n_valid = 0, n_beyond = 0;
	int n_loads = 0, n_dropped = 0, n_clears = 0, n_spare = 0;
	logic word_taken = 1'b0;
	int hold_off = 0;
	bit calm = 1'b0;
	cmd_word_t cur;

	function automatic logic [15:0] find_opposite(input logic [15:0] p, q, own);
		logic [15:0] v1, v2, v3;
		for (int i = 0; i < mesh_len; i++) begin
			for (int e = 0; e < 3; e++) begin
				v1 = mesh_vtx[i][e];
				v2 = mesh_vtx[i][(e + 1) % 3];
				v3 = mesh_vtx[i][(e + 2) % 3];
				if (((v1 == p && v2 == q) || (v1 == q && v2 == p)) && v3 != own)
					return v3;
			end
		end
		return '0;
	endfunction

	task automatic check_field(input string name, input logic [15:0] exp_v, act_v);
		if (exp_v !== act_v) begin
			$display("%0t ns: %s expected %h, got %h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	task automatic queue_cmd(input logic [1:0] m, input logic [15:0] a, b, c,
			input logic [9:0] q);
		cmd_word_t w;
		w.mode = m;
		w.va = a;
		w.vb = b;
		w.vc = c;
		w.qt = q;
		cmd_backlog.push_back(w);
		if (m == tab_pkg::MODE_CLEAR)
			gen_len = 0;
		else if (m == tab_pkg::MODE_LOAD && gen_len < NUM_TRI) begin
			gen_v[gen_len][0] = a;
			gen_v[gen_len][1] = b;
			gen_v[gen_len][2] = c;
			gen_len++;
		end
	endtask

	task automatic ask(input logic [9:0] q);
		queue_cmd(tab_pkg::MODE_QUERY, 16'($urandom), 16'($urandom), 16'($urandom), q);
	endtask

	// Append a triangle that usually shares an edge with one already loaded, in either
	// direction and at any rotation; now and then it repeats the neighbour's third vertex.
	task automatic mesh_tri(input logic [15:0] base, input int spread);
		logic [15:0] t [0:2];
		int src, e, r;
		if (gen_len > 0 && $urandom_range(0, 3) != 0) begin
			src = $urandom_range(0, gen_len - 1);
			e = $urandom_range(0, 2);
			if ($urandom_range(0, 1)) begin
				t[0] = gen_v[src][(e + 1) % 3];
				t[1] = gen_v[src][e];
			end else begin
				t[0] = gen_v[src][e];
				t[1] = gen_v[src][(e + 1) % 3];
			end
			if ($urandom_range(0, 4) == 0)
				t[2] = gen_v[src][(e + 2) % 3];
			else
				t[2] = base + 16'($urandom_range(0, spread));
		end else begin
			for (int k = 0; k < 3; k++)
				t[k] = base + 16'($urandom_range(0, spread));
		end
		r = $urandom_range(0, 2);
		queue_cmd(tab_pkg::MODE_LOAD, t[r], t[(r + 1) % 3], t[(r + 2) % 3],
			10'($urandom_range(0, 1023)));
	endtask

	function automatic int next_gap();
		if ($urandom_range(0, 49) == 0)
			calm = !calm;
		if (calm)
			return 0;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return 0;
			6, 7, 8: return $urandom_range(1, 3);
			default: return $urandom_range(8, 60);
		endcase
	endfunction

	// driver: present the next word once the held one is taken, after its gap
	always @(negedge clk) begin
		if (arst_n && (!start || word_taken)) begin
			if (hold_off > 0) begin
				start <= 1'b0;
				hold_off <= hold_off - 1;
			end else if (cmd_backlog.size() != 0) begin
				cur = cmd_backlog.pop_front();
				mode <= cur.mode;
				vertex_a <= cur.va;
				vertex_b <= cur.vb;
				vertex_c <= cur.vc;
				query_triangle <= cur.qt;
				start <= 1'b1;
				hold_off <= next_gap();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: check results, then apply the accepted word to the table model
	always @(posedge clk) begin : monitor
		adj_word_t want, got;
		if (arst_n) begin
			word_taken <= start && !busy;
			if (strobe) begin
				if (adj_expected.size() == 0) begin
					$display("%0t ns: adjacency record with none expected", $time);
					errors++;
				end else begin
					want = adj_expected.pop_front();
					check_field("valid_res", {15'd0, want.valid}, {15'd0, valid_res});
					check_field("corner_a", want.ca, corner_a);
					check_field("across_ab", want.ab, across_ab);
					check_field("corner_b", want.cb, corner_b);
					check_field("across_bc", want.bc, across_bc);
					check_field("corner_c", want.cc, corner_c);
					check_field("across_ca", want.ac, across_ca);
					n_checked++;
				end
			end
			if (start && !busy) begin
				case (mode)
					tab_pkg::MODE_LOAD: begin
						if (mesh_len < NUM_TRI) begin
							mesh_vtx[mesh_len][0] = vertex_a;
							mesh_vtx[mesh_len][1] = vertex_b;
							mesh_vtx[mesh_len][2] = vertex_c;
							mesh_len++;
							n_loads++;
						end else begin
							n_dropped++;
						end
					end
					tab_pkg::MODE_CLEAR: begin
						mesh_len = 0;
						n_clears++;
					end
					tab_pkg::MODE_QUERY: begin
						got = '0;
						if (query_triangle < mesh_len) begin
							got.valid = 1'b1;
							got.ca = mesh_vtx[query_triangle][0];
							got.cb = mesh_vtx[query_triangle][1];
							got.cc = mesh_vtx[query_triangle][2];
							got.ab = find_opposite(got.ca, got.cb, got.cc);
							got.bc = find_opposite(got.cb, got.cc, got.ca);
							got.ac = find_opposite(got.cc, got.ca, got.cb);
							n_valid++;
						end else begin
							n_beyond++;
						end
						adj_expected.push_back(got);
					end
					default: n_spare++;
				endcase
			end
			if (strobe || (start && !busy))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
		end
	end

	always @(posedge clk) begin
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t ns: no word moved for %0d cycles", $time, STALL_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int rand_items, n, nq;
		logic [15:0] base;
		int spread;

		// directed: empty table, unused mode, shared edges both ways, extremes
		ask(10'd0);
		queue_cmd(MODE_SPARE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'h3FF);
		queue_cmd(tab_pkg::MODE_LOAD, 16'd1, 16'd2, 16'd3, 10'd0);
		queue_cmd(tab_pkg::MODE_LOAD, 16'd3, 16'd2, 16'd4, 10'h3FF);
		queue_cmd(tab_pkg::MODE_LOAD, 16'd1, 16'd2, 16'd3, 10'd0);
		queue_cmd(tab_pkg::MODE_LOAD, 16'd2, 16'd1, 16'd3, 10'd0);
		queue_cmd(tab_pkg::MODE_LOAD, 16'hFFFF, 16'd0, 16'hFFFF, 10'd0);
		queue_cmd(tab_pkg::MODE_LOAD, 16'd0, 16'hFFFF, 16'd7, 10'd0);
		queue_cmd(tab_pkg::MODE_LOAD, 16'd5, 16'd6, 16'd7, 10'd0);
		for (int i = 0; i <= 7; i++)
			ask(10'(i));
		ask(10'h3FF);
		queue_cmd(tab_pkg::MODE_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'h3FF);
		ask(10'd0);

		// random: mostly small meshes with queries, some noise words
		rand_items = 0;
		while (rand_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 99) < 15) begin
				n = $urandom_range(0, 3);
				queue_cmd(2'(n), 16'($urandom), 16'($urandom), 16'($urandom),
					10'($urandom));
				if (n != MODE_SPARE)
					rand_items++;
			end else begin
				if (gen_len > 150 || $urandom_range(0, 9) < 7) begin
					queue_cmd(tab_pkg::MODE_CLEAR, 16'($urandom), 16'($urandom),
						16'($urandom), 10'($urandom));
					rand_items++;
				end
				base = 16'($urandom);
				spread = $urandom_range(2, 12);
				n = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 12);
				for (int i = 0; i < n; i++)
					mesh_tri(base, spread);
				nq = $urandom_range(2, 8);
				for (int i = 0; i < nq; i++) begin
					if ($urandom_range(0, 5) == 0)
						ask(10'($urandom_range(0, 1023)));
					else
						ask(10'($urandom_range(0, gen_len - 1)));
				end
				rand_items += n + nq;
			end
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (cmd_backlog.size() != 0 || start)
			@(posedge clk);
		while (adj_expected.size() != 0)
			@(posedge clk);
		// catch any stray record after the last one
		repeat (16) @(posedge clk);

		$display("Checked %0d adjacency records: %0d in range, %0d beyond the count.",
			n_checked, n_valid, n_beyond);
		$display("Words: %0d loads, %0d dropped on a full table, %0d clears, %0d unused mode.",
			n_loads, n_dropped, n_clears, n_spare);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/tab_pkg.sv
hw/rtl/tab_ram.sv
hw/rtl/tab_cell.sv
hw/rtl/triangle_adjacency_builder_core.sv
test/triangle_adjacency_builder_core_test.sv
